// ===== rtl/gregorian_date_ordinal_convert_assert.svh =====
// ----------------------------------------------------------------------------
// gregorian_date_ordinal_convert_assert.svh
// assertion helper macros used by the result stage of the converter pipeline
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ORDINAL_CONVERT_ASSERT_SVH
`define GREGORIAN_DATE_ORDINAL_CONVERT_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define GDOC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdoc assertion failed");

// next-cycle implication, disabled while reset is high
`define GDOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdoc assertion failed");

`endif

// ===== rtl/gdoc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdoc_pkg
// shared constants, calendar tables and stage types of the date converter
// ----------------------------------------------------------------------------
package gdoc_pkg;

   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 9;
   localparam int DOM_W   = 5;
   localparam int YMAG_W  = YEAR_W - 1;
   localparam int GT_W    = 11;

   // conversion modes
   localparam logic MODE_TO_ORDINAL = 1'b0;
   localparam logic MODE_TO_DATE    = 1'b1;

   // divisibility by 25 through the modular inverse of 25 mod 2**15
   localparam logic [YMAG_W-1:0] INV25     = 15'd23593;
   localparam logic [YMAG_W-1:0] DIV25_MAX = 15'd1310;

   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [DAY_W-1:0]   YEAR_DAYS   = 9'd365;
   localparam logic [DAY_W-1:0]   LEAP_DAYS   = 9'd366;

   typedef struct packed {
      logic                mode;
      logic                neg;
      logic [3:0]          yr_lo;
      logic [YMAG_W-1:0]   prod;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day_value;
   } s1_type;

   typedef struct packed {
      logic                mode;
      logic                err;
      logic                leap;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day_value;
      logic [GT_W-1:0]     gt;
   } s2_type;

   function automatic logic [DOM_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
      logic [DOM_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days of the year that come before the first of month m
   function automatic logic [DAY_W-1:0] cum_before(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] base;
      unique case (m)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd3) && (m <= MONTH_LAST)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// ===== rtl/gdoc_front.sv =====
// ----------------------------------------------------------------------------
// gdoc_front
// stage one: captures the word and forms the divide-by-25 test product
// ----------------------------------------------------------------------------
module gdoc_front
   import gdoc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      in_mode,
   input  logic signed [YEAR_W-1:0]  in_year,
   input  logic [MONTH_W-1:0]        in_month,
   input  logic [DAY_W-1:0]          in_day_value,
   output logic                      s1_valid,
   output s1_type                    s1
);

   logic [YMAG_W-1:0]   prod_lo;
   logic                valid_ff;
   s1_type              s1_ff;
   s1_type              s1_in;

   // only the product modulo 2**15 matters for the test
   assign prod_lo = in_year[YMAG_W-1:0] * INV25;

   always_comb begin
      s1_in.mode      = in_mode;
      s1_in.neg       = in_year[YEAR_W-1];
      s1_in.yr_lo     = in_year[3:0];
      s1_in.prod      = prod_lo;
      s1_in.month     = in_month;
      s1_in.day_value = in_day_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = valid_ff;
   assign s1       = s1_ff;

endmodule

// ===== rtl/gdoc_check.sv =====
// ----------------------------------------------------------------------------
// gdoc_check
// stage two: leap year, range checks and month boundary compares
// ----------------------------------------------------------------------------
module gdoc_check
   import gdoc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   s1_valid,
   input  s1_type s1,
   output logic   s2_valid,
   output s2_type s2
);

   logic   div25;
   logic   leap;
   logic   err_ord;
   logic   err_date;
   logic   valid_ff;
   s2_type s2_ff;
   s2_type s2_in;

   assign div25 = (s1.prod <= DIV25_MAX);
   // div by 100 is div by 4 and 25, div by 400 is div by 16 and 25
   assign leap  = ((s1.yr_lo[1:0] == 2'd0) && !div25) ||
                  ((s1.yr_lo == 4'd0) && div25);

   assign err_ord = (s1.month < MONTH_FIRST) || (s1.month > MONTH_LAST) ||
                    (s1.day_value == '0) ||
                    (s1.day_value > {{(DAY_W-DOM_W){1'b0}}, month_len(leap, s1.month)});
   assign err_date = (s1.day_value == '0) ||
                     (s1.day_value > (leap ? LEAP_DAYS : YEAR_DAYS));

   always_comb begin
      s2_in.mode      = s1.mode;
      s2_in.leap      = leap;
      s2_in.month     = s1.month;
      s2_in.day_value = s1.day_value;
      s2_in.err       = s1.neg || ((s1.mode == MODE_TO_ORDINAL) ? err_ord : err_date);
      // bit i: ordinal lies past the end of month i+1
      for (int i = 0; i < GT_W; i++) begin
         s2_in.gt[i] = s1.day_value > cum_before(leap, MONTH_W'(i + 2));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   assign s2_valid = valid_ff;
   assign s2       = s2_ff;

endmodule

// ===== rtl/gdoc_back.sv =====
// ----------------------------------------------------------------------------
// gdoc_back
// stage three: ordinal sum or month pick, result register and strobe
// ----------------------------------------------------------------------------
module gdoc_back
   import gdoc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               s2_valid,
   input  s2_type             s2,
   output logic               out_valid,
   output logic [DAY_W-1:0]   out_ordinal_day,
   output logic [MONTH_W-1:0] out_month_out,
   output logic [DOM_W-1:0]   out_day_of_month,
   output logic               out_error
);

`include "gregorian_date_ordinal_convert_assert.svh"

   logic [MONTH_W-1:0] pick_month;
   logic [DAY_W-1:0]   pick_day;
   logic [DAY_W-1:0]   ord_sum;

   logic               valid_ff;
   logic [DAY_W-1:0]   ord_ff;
   logic [DAY_W-1:0]   ord_in;
   logic [MONTH_W-1:0] mon_ff;
   logic [MONTH_W-1:0] mon_in;
   logic [DOM_W-1:0]   dom_ff;
   logic [DOM_W-1:0]   dom_in;
   logic               err_ff;
   logic               err_in;

   assign ord_sum = s2.day_value + cum_before(s2.leap, s2.month);
   // boundary flags are monotone, so their count gives the month
   assign pick_month = MONTH_FIRST + MONTH_W'($countones(s2.gt));
   assign pick_day   = s2.day_value - cum_before(s2.leap, pick_month);

   always_comb begin
      ord_in = '0;
      mon_in = '0;
      dom_in = '0;
      err_in = s2.err;
      if (!s2.err) begin
         if (s2.mode == MODE_TO_ORDINAL) begin
            ord_in = ord_sum;
         end else begin
            mon_in = pick_month;
            dom_in = pick_day[DOM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff <= ord_in;
      mon_ff <= mon_in;
      dom_ff <= dom_in;
      err_ff <= err_in;
   end

   assign out_valid        = valid_ff;
   assign out_ordinal_day  = ord_ff;
   assign out_month_out    = mon_ff;
   assign out_day_of_month = dom_ff;
   assign out_error        = err_ff;

   `GDOC_ASSERT_NEXT(a_valid_follows, clock, reset, s2_valid, out_valid)
   `GDOC_ASSERT_SAME(a_err_zero, clock, reset, out_valid && out_error, (ord_ff == '0) && (mon_ff == '0) && (dom_ff == '0))
   `GDOC_ASSERT_SAME(a_one_mode, clock, reset, out_valid && !out_error, (ord_ff != '0) ^ (mon_ff != '0))
   `GDOC_ASSERT_SAME(a_date_range, clock, reset, out_valid && (mon_ff != '0), (mon_ff <= MONTH_LAST) && (dom_ff != '0))

endmodule

// ===== rtl/gregorian_date_ordinal_convert.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_ordinal_convert
// gregorian date to day-of-year converter and back, with range checking
// ----------------------------------------------------------------------------
// A word is taken on every clock edge where start is high; busy never rises,
// so one conversion enters per cycle. Each result passes the multiply stage,
// check stage and result stage registers, reaches the rsp_ ports in order
// and is shown for one cycle with rsp_valid high. The receiver cannot stall,
// so nothing is buffered beyond the three pipeline registers. On an invalid
// year or day, or an invalid month in date-to-ordinal mode, rsp_error is set
// and the other fields read zero.
module gregorian_date_ordinal_convert
   import gdoc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic signed [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0]        req_month,
   input  logic [DAY_W-1:0]          req_day_value,
   output logic                      rsp_valid,
   output logic [DAY_W-1:0]          rsp_ordinal_day,
   output logic [MONTH_W-1:0]        rsp_month_out,
   output logic [DOM_W-1:0]          rsp_day_of_month,
   output logic                      rsp_error
);

   logic   accept;
   logic   s1_valid;
   s1_type s1;
   logic   s2_valid;
   s2_type s2;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   gdoc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_mode      (req_mode),
      .in_year      (req_year),
      .in_month     (req_month),
      .in_day_value (req_day_value),
      .s1_valid     (s1_valid),
      .s1           (s1)
   );

   gdoc_check u_check (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   gdoc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .s2_valid         (s2_valid),
      .s2               (s2),
      .out_valid        (rsp_valid),
      .out_ordinal_day  (rsp_ordinal_day),
      .out_month_out    (rsp_month_out),
      .out_day_of_month (rsp_day_of_month),
      .out_error        (rsp_error)
   );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gregorian date / day-of-year converter: directed
// calendar corners in both modes, then well-formed and raw random words with
// random gaps, each result compared against an in-bench calendar predictor
// ----------------------------------------------------------------------------
module tb_top
   import gdoc_pkg::*;
();

   localparam int IDLE_LIMIT  = 1000;
   localparam int DRAIN_WAIT  = 8;
   localparam int N_WELLFORM  = 450;
   localparam int N_RAW       = 150;

   typedef struct packed {
      logic [DAY_W-1:0]   ordinal_day;
      logic [MONTH_W-1:0] month_out;
      logic [DOM_W-1:0]   day_of_month;
      logic               error;
   } date_result_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_mode;
   logic signed [YEAR_W-1:0] req_year;
   logic [MONTH_W-1:0]       req_month;
   logic [DAY_W-1:0]         req_day_value;
   logic                     rsp_valid;
   logic [DAY_W-1:0]         rsp_ordinal_day;
   logic [MONTH_W-1:0]       rsp_month_out;
   logic [DOM_W-1:0]         rsp_day_of_month;
   logic                     rsp_error;

   date_result_type pending_dates[$];
   int              mismatch_count;
   int              idle_cycles;
   int              back_to_back_left;

   gregorian_date_ordinal_convert dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_year         (req_year),
      .req_month        (req_month),
      .req_day_value    (req_day_value),
      .rsp_valid        (rsp_valid),
      .rsp_ordinal_day  (rsp_ordinal_day),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_error        (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int days_in_month(input bit leap, input int m);
      int n;
      case (m)
         1, 3, 5, 7, 8, 10, 12: n = 31;
         4, 6, 9, 11:           n = 30;
         2:                     n = leap ? 29 : 28;
         default:               n = 0;
      endcase
      return n;
   endfunction

   function automatic bit is_leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic date_result_type convert_date(input logic mode,
                                                    input logic signed [YEAR_W-1:0] year,
                                                    input logic [MONTH_W-1:0] month,
                                                    input logic [DAY_W-1:0] day_value);
      date_result_type r;
      bit              leap;
      int unsigned     m;
      int unsigned     d;
      r = '0;
      if (year[YEAR_W-1]) begin
         r.error = 1'b1;
         return r;
      end
      leap = is_leap_year(int'(year));
      if (mode == MODE_TO_ORDINAL) begin
         if (month < 1 || month > 12 || day_value < 1 ||
             day_value > days_in_month(leap, int'(month))) begin
            r.error = 1'b1;
         end else begin
            d = int'(day_value);
            for (m = 1; m < month; m++) d += days_in_month(leap, m);
            r.ordinal_day = d[DAY_W-1:0];
         end
      end else begin
         if (day_value < 1 || day_value > (leap ? 366 : 365)) begin
            r.error = 1'b1;
         end else begin
            d = int'(day_value);
            m = 1;
            while (m < 12 && d > days_in_month(leap, m)) begin
               d -= days_in_month(leap, m);
               m++;
            end
            r.month_out    = m[MONTH_W-1:0];
            r.day_of_month = d[DOM_W-1:0];
         end
      end
      return r;
   endfunction

   // drive one word after a random gap, hold it until taken, then log the prediction
   task automatic send_word(input logic mode, input logic signed [YEAR_W-1:0] year,
                            input logic [MONTH_W-1:0] month,
                            input logic [DAY_W-1:0] day_value);
      int gap;
      if (back_to_back_left > 0) begin
         gap = 0;
         back_to_back_left--;
      end else begin
         gap = $urandom_range(0, 19);
         if ($urandom_range(0, 15) == 0) back_to_back_left = $urandom_range(5, 30);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_mode      <= mode;
      req_year      <= year;
      req_month     <= month;
      req_day_value <= day_value;
      do @(posedge clock); while (busy);
      pending_dates.push_back(convert_date(mode, year, month, day_value));
   endtask

   task automatic wait_pending_empty();
      if (start) start <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic test_date_to_ordinal();
      send_word(MODE_TO_ORDINAL, 16'sd2023, 4'd1, 9'd1);
      send_word(MODE_TO_ORDINAL, 16'sd2023, 4'd12, 9'd31);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd12, 9'd31);
      send_word(MODE_TO_ORDINAL, 16'sd2000, 4'd2, 9'd29);
      send_word(MODE_TO_ORDINAL, 16'sd1900, 4'd2, 9'd29);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd3, 9'd1);
      // year zero counts as leap
      send_word(MODE_TO_ORDINAL, 16'sd0, 4'd2, 9'd29);
      send_word(MODE_TO_ORDINAL, 16'sd32767, 4'd6, 9'd30);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd0, 9'd5);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd13, 9'd5);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd15, 9'd5);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd7, 9'd0);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd4, 9'd31);
      send_word(MODE_TO_ORDINAL, 16'sd2024, 4'd1, 9'd511);
      send_word(MODE_TO_ORDINAL, -16'sd1, 4'd5, 9'd5);
      send_word(MODE_TO_ORDINAL, -16'sd32768, 4'd1, 9'd1);
      wait_pending_empty();
   endtask

   task automatic test_ordinal_to_date();
      send_word(MODE_TO_DATE, 16'sd2023, 4'd15, 9'd1);
      send_word(MODE_TO_DATE, 16'sd2023, 4'd0, 9'd59);
      send_word(MODE_TO_DATE, 16'sd2023, 4'd7, 9'd60);
      send_word(MODE_TO_DATE, 16'sd2024, 4'd3, 9'd60);
      send_word(MODE_TO_DATE, 16'sd2023, 4'd1, 9'd365);
      send_word(MODE_TO_DATE, 16'sd2023, 4'd2, 9'd366);
      send_word(MODE_TO_DATE, 16'sd2400, 4'd9, 9'd366);
      send_word(MODE_TO_DATE, 16'sd2100, 4'd9, 9'd366);
      send_word(MODE_TO_DATE, 16'sd0, 4'd12, 9'd367);
      send_word(MODE_TO_DATE, 16'sd2024, 4'd4, 9'd0);
      send_word(MODE_TO_DATE, 16'sd32767, 4'd4, 9'd511);
      send_word(MODE_TO_DATE, -16'sd32768, 4'd1, 9'd100);
      wait_pending_empty();
   endtask

   function automatic logic signed [YEAR_W-1:0] pick_year();
      int unsigned y;
      case ($urandom_range(0, 3))
         0:       y = $urandom_range(0, 32767);
         1:       y = $urandom_range(0, 8191) * 4;
         2:       y = $urandom_range(0, 327) * 100;
         default: y = $urandom_range(0, 81) * 400;
      endcase
      return y[YEAR_W-1:0];
   endfunction

   task automatic test_wellformed_random();
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      int                       lim;
      int                       dv;
      repeat (N_WELLFORM) begin
         year  = pick_year();
         month = MONTH_W'($urandom_range(1, 12));
         if ($urandom_range(0, 1) == 0) begin
            lim = days_in_month(is_leap_year(int'(year)), int'(month));
            case ($urandom_range(0, 7))
               0:       dv = lim;
               1:       dv = lim + 1;
               default: dv = $urandom_range(1, lim);
            endcase
            send_word(MODE_TO_ORDINAL, year, month, dv[DAY_W-1:0]);
         end else begin
            case ($urandom_range(0, 7))
               0:       dv = $urandom_range(365, 367);
               1:       dv = $urandom_range(58, 61);
               default: dv = $urandom_range(1, 366);
            endcase
            send_word(MODE_TO_DATE, year, MONTH_W'($urandom_range(0, 15)),
                      dv[DAY_W-1:0]);
         end
      end
      wait_pending_empty();
   endtask

   task automatic test_raw_random();
      repeat (N_RAW) begin
         send_word(1'($urandom_range(0, 1)), YEAR_W'($urandom_range(0, 65535)),
                   MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 511)));
      end
      wait_pending_empty();
   endtask

   // result checker: the receiver never stalls, so every strobe is a taken word
   always @(posedge clock) begin
      date_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            $error("result word with no prediction pending");
            mismatch_count++;
         end else begin
            exp_r = pending_dates.pop_front();
            if (rsp_ordinal_day !== exp_r.ordinal_day) begin
               $error("ordinal_day: expected %0d, actual %0d",
                      exp_r.ordinal_day, rsp_ordinal_day);
               mismatch_count++;
            end
            if (rsp_month_out !== exp_r.month_out) begin
               $error("month_out: expected %0d, actual %0d",
                      exp_r.month_out, rsp_month_out);
               mismatch_count++;
            end
            if (rsp_day_of_month !== exp_r.day_of_month) begin
               $error("day_of_month: expected %0d, actual %0d",
                      exp_r.day_of_month, rsp_day_of_month);
               mismatch_count++;
            end
            if (rsp_error !== exp_r.error) begin
               $error("error: expected %0d, actual %0d", exp_r.error, rsp_error);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles where neither side moves a word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mismatch_count    = 0;
      back_to_back_left = 0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_mode          <= MODE_TO_ORDINAL;
      req_year          <= '0;
      req_month         <= '0;
      req_day_value     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_date_to_ordinal();
      test_ordinal_to_date();
      test_wellformed_random();
      test_raw_random();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_dates.size() != 0) begin
         $error("%0d predicted results never arrived", pending_dates.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
